[rtl/fresnel_dielectric_reflectance_assert.svh]
// assertion macros for the fresnel reflectance block
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_ASSERT_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FDR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fdr assertion failed");
`define FDR_ASSERT_NEVER(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("fdr forbidden condition seen");
`else
`define FDR_ASSERT(name, clk, rst_n, prop)
`define FDR_ASSERT_NEVER(name, clk, rst_n, prop)
`endif
`endif

[rtl/fdr_pkg.sv]
// shared constants and request/result types for the fresnel reflectance pipeline
package fdr_pkg;

  localparam int VECTOR_FRACTION_BITS = 14;
  localparam int INT_BITS    = 30;
  localparam int ROOT_W      = INT_BITS + 1;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int REM_W       = ROOT_W + 2;
  localparam int DIV_STAGES  = INT_BITS;
  localparam int IDX_W       = 16;
  localparam int IDX_FRAC    = 12;
  localparam int PROD_W      = IDX_W + ROOT_W;
  localparam int DEN_W       = PROD_W + 1;
  localparam int RES_W       = 16;
  localparam int LATENCY     = 3 + SQRT_STAGES + 1 + DIV_STAGES + 1 + SQRT_STAGES + 3
                               + DIV_STAGES + 2;

  localparam logic [IDX_W-1:0]  INDEX_ONE  = IDX_W'(1) << IDX_FRAC;
  localparam logic [RES_W-1:0]  RESULT_ONE = RES_W'(1) << (RES_W - 1);
  localparam logic [ROOT_W-1:0] Q_ONE      = ROOT_W'(1) << INT_BITS;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] incident_x;
    logic signed [15:0] incident_y;
    logic signed [15:0] incident_z;
    logic [15:0]        refractive_index;
  } req_t;

  typedef struct packed {
    logic [RES_W-1:0] reflectance;
    logic             total_internal;
  } res_t;

endpackage

[rtl/fresnel_dielectric_reflectance.sv]
// fresnel reflectance pipeline top level
// the path from start to valid_o runs through two 31-stage square roots
// and two 30-stage dividers in series
// throughput: one request per cycle, busy is never raised
// reset clears all valid bits; data registers are not reset
`include "fresnel_dielectric_reflectance_assert.svh"
module fresnel_dielectric_reflectance (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  fdr_pkg::req_t   req_i,
  output logic            valid_o,
  output fdr_pkg::res_t   res_o
);

  localparam int TwoV = 2 * fdr_pkg::VECTOR_FRACTION_BITS;
  localparam int Shr  = (TwoV >= fdr_pkg::INT_BITS) ? TwoV - fdr_pkg::INT_BITS : 0;
  localparam int Shl  = (TwoV >= fdr_pkg::INT_BITS) ? 0 : fdr_pkg::INT_BITS - TwoV;
  localparam logic signed [63:0] DotOne = 64'sd1 <<< TwoV;
  localparam int RW = fdr_pkg::ROOT_W;
  localparam int IW = fdr_pkg::IDX_W;
  localparam int PW = fdr_pkg::PROD_W;
  localparam int DW = fdr_pkg::DEN_W;
  localparam int HiW = RW - (fdr_pkg::INT_BITS - fdr_pkg::IDX_FRAC);

  typedef struct packed {
    logic [RW-1:0] cosi;
    logic          pos;
    logic [IW-1:0] ior;
  } side1_t;

  typedef struct packed {
    logic [RW-1:0]                 cosi;
    logic                          pos;
    logic [IW-1:0]                 ior;
    logic                          mtir;
    logic [fdr_pkg::INT_BITS-1:0]  mval;
    logic                          dtir;
  } side2_t;

  typedef struct packed {
    logic [RW-1:0] cosi;
    logic [IW-1:0] eta_i;
    logic [IW-1:0] eta_t;
    logic          tir;
  } side3_t;

  typedef struct packed {
    logic ge_s;
    logic ge_p;
    logic tir;
  } side4_t;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // products of the dot
  logic               v1_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic [IW-1:0]      ior1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= req_i.normal_x * req_i.incident_x;
    py_q   <= req_i.normal_y * req_i.incident_y;
    pz_q   <= req_i.normal_z * req_i.incident_z;
    ior1_q <= (req_i.refractive_index == '0) ? IW'(1) : req_i.refractive_index;
  end

  // cosine, clamp, magnitude
  logic signed [63:0] dot_w, cosv_w, cosc_w;
  logic [63:0]        mag_w, cosi_w;
  logic               v2_q;
  side1_t             s2_q;

  always_comb begin
    dot_w  = 64'(px_q) + 64'(py_q) + 64'(pz_q);
    cosv_w = -dot_w;
    cosc_w = cosv_w;
    if (cosv_w > DotOne) begin
      cosc_w = DotOne;
    end
    if (cosv_w < -DotOne) begin
      cosc_w = -DotOne;
    end
    mag_w  = (cosc_w < 0) ? 64'(-cosc_w) : 64'(cosc_w);
    cosi_w = (mag_w >> Shr) << Shl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q.cosi <= cosi_w[RW-1:0];
    s2_q.pos  <= cosc_w > 0;
    s2_q.ior  <= ior1_q;
  end

  // cos squared
  logic [2*RW-1:0]           c2p_w;
  logic [RW-1:0]             c2_w;
  logic                      v3_q;
  logic [fdr_pkg::RAD_W-1:0] rad1_q;
  side1_t                    s3_q;

  assign c2p_w = s2_q.cosi * s2_q.cosi;
  assign c2_w  = c2p_w[fdr_pkg::INT_BITS +: RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad1_q <= fdr_pkg::RAD_W'({fdr_pkg::Q_ONE - c2_w, fdr_pkg::INT_BITS'(0)});
    s3_q   <= s2_q;
  end

  // sine of incidence
  logic          sq1_v;
  logic [RW-1:0] sini;
  side1_t        d1_q [fdr_pkg::SQRT_STAGES];

  fdr_sqrt u_sqrt_i (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .rad_i   (rad1_q),
    .valid_o (sq1_v),
    .root_o  (sini)
  );

  always_ff @(posedge clk_i) begin
    d1_q[0] <= s3_q;
    for (int i = 1; i < fdr_pkg::SQRT_STAGES; i++) begin
      d1_q[i] <= d1_q[i-1];
    end
  end

  side1_t s4_w;
  assign s4_w = d1_q[fdr_pkg::SQRT_STAGES-1];

  // snell: multiply path when leaving, divide path when entering
  logic [PW-1:0]                 mul_w;
  logic [HiW-1:0]                hi_w;
  logic                          v4_q;
  side2_t                        s4_q;
  logic [DW-1:0]                 dv_rem_q, dv_den_q;
  logic [fdr_pkg::DIV_STAGES-1:0] dv_low_q;

  assign mul_w = PW'(sini) * PW'(s4_w.ior);
  assign hi_w  = sini[RW-1 -: HiW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= sq1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_q.cosi <= s4_w.cosi;
    s4_q.pos  <= s4_w.pos;
    s4_q.ior  <= s4_w.ior;
    s4_q.mtir <= |mul_w[PW-1:fdr_pkg::INT_BITS+fdr_pkg::IDX_FRAC];
    s4_q.mval <= mul_w[fdr_pkg::IDX_FRAC +: fdr_pkg::INT_BITS];
    s4_q.dtir <= IW'(hi_w) >= s4_w.ior;
    dv_rem_q  <= DW'(hi_w);
    dv_den_q  <= DW'(s4_w.ior);
    dv_low_q  <= {sini[fdr_pkg::INT_BITS-fdr_pkg::IDX_FRAC-1:0],
                  fdr_pkg::IDX_FRAC'(0)};
  end

  logic                           dv1_v;
  logic [fdr_pkg::DIV_STAGES-1:0] dv1_q;
  side2_t                         d2_q [fdr_pkg::DIV_STAGES];

  fdr_div u_div_snell (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .rem_i   (dv_rem_q),
    .den_i   (dv_den_q),
    .low_i   (dv_low_q),
    .valid_o (dv1_v),
    .quo_o   (dv1_q)
  );

  always_ff @(posedge clk_i) begin
    d2_q[0] <= s4_q;
    for (int i = 1; i < fdr_pkg::DIV_STAGES; i++) begin
      d2_q[i] <= d2_q[i-1];
    end
  end

  // transmitted sine squared
  side2_t                         s5_w;
  logic [fdr_pkg::INT_BITS-1:0]   sint_w;
  logic [2*fdr_pkg::INT_BITS-1:0] st2p_w;
  logic                           v5_q;
  logic [fdr_pkg::RAD_W-1:0]      rad2_q;
  side3_t                         s5_q;

  assign s5_w   = d2_q[fdr_pkg::DIV_STAGES-1];
  assign sint_w = s5_w.pos ? s5_w.mval : dv1_q;
  assign st2p_w = sint_w * sint_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= dv1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    rad2_q     <= fdr_pkg::RAD_W'({fdr_pkg::Q_ONE
                  - RW'(st2p_w[fdr_pkg::INT_BITS +: fdr_pkg::INT_BITS]),
                  fdr_pkg::INT_BITS'(0)});
    s5_q.cosi  <= s5_w.cosi;
    s5_q.eta_i <= s5_w.pos ? s5_w.ior : fdr_pkg::INDEX_ONE;
    s5_q.eta_t <= s5_w.pos ? fdr_pkg::INDEX_ONE : s5_w.ior;
    s5_q.tir   <= s5_w.pos ? s5_w.mtir : s5_w.dtir;
  end

  logic          sq2_v;
  logic [RW-1:0] cost;
  side3_t        d3_q [fdr_pkg::SQRT_STAGES];

  fdr_sqrt u_sqrt_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .rad_i   (rad2_q),
    .valid_o (sq2_v),
    .root_o  (cost)
  );

  always_ff @(posedge clk_i) begin
    d3_q[0] <= s5_q;
    for (int i = 1; i < fdr_pkg::SQRT_STAGES; i++) begin
      d3_q[i] <= d3_q[i-1];
    end
  end

  // amplitude products
  side3_t        s7_w;
  logic          v7_q, tir7_q;
  logic [PW-1:0] as_q, bs_q, ap_q, bp_q;

  assign s7_w = d3_q[fdr_pkg::SQRT_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= sq2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    as_q   <= PW'(s7_w.eta_t) * PW'(s7_w.cosi);
    bs_q   <= PW'(s7_w.eta_i) * PW'(cost);
    ap_q   <= PW'(s7_w.eta_i) * PW'(s7_w.cosi);
    bp_q   <= PW'(s7_w.eta_t) * PW'(cost);
    tir7_q <= s7_w.tir;
  end

  // numerator and denominator
  logic          v8_q, tir8_q;
  logic [DW-1:0] nums_q, dens_q, nump_q, denp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else begin
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nums_q <= (as_q >= bs_q) ? DW'(as_q - bs_q) : DW'(bs_q - as_q);
    dens_q <= DW'(as_q) + DW'(bs_q);
    nump_q <= (ap_q >= bp_q) ? DW'(ap_q - bp_q) : DW'(bp_q - ap_q);
    denp_q <= DW'(ap_q) + DW'(bp_q);
    tir8_q <= tir7_q;
  end

  // integer bit of each ratio
  logic          ges_w, gep_w;
  logic          v9_q;
  side4_t        s9_q;
  logic [DW-1:0] rems_q, remp_q, dens9_q, denp9_q;

  assign ges_w = nums_q >= dens_q;
  assign gep_w = nump_q >= denp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q <= 1'b0;
    end else begin
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rems_q    <= ges_w ? nums_q - dens_q : nums_q;
    remp_q    <= gep_w ? nump_q - denp_q : nump_q;
    dens9_q   <= dens_q;
    denp9_q   <= denp_q;
    s9_q.ge_s <= ges_w;
    s9_q.ge_p <= gep_w;
    s9_q.tir  <= tir8_q;
  end

  logic                           dvs_v, dvp_v;
  logic [fdr_pkg::DIV_STAGES-1:0] qs_w, qp_w;
  side4_t                         d4_q [fdr_pkg::DIV_STAGES];

  fdr_div u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v9_q),
    .rem_i   (rems_q),
    .den_i   (dens9_q),
    .low_i   ('0),
    .valid_o (dvs_v),
    .quo_o   (qs_w)
  );

  fdr_div u_div_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v9_q),
    .rem_i   (remp_q),
    .den_i   (denp9_q),
    .low_i   ('0),
    .valid_o (dvp_v),
    .quo_o   (qp_w)
  );

  always_ff @(posedge clk_i) begin
    d4_q[0] <= s9_q;
    for (int i = 1; i < fdr_pkg::DIV_STAGES; i++) begin
      d4_q[i] <= d4_q[i-1];
    end
  end

  // squared ratios
  side4_t          s10_w;
  logic [RW-1:0]   rs_w, rp_w;
  logic [2*RW-1:0] rs2p_w, rp2p_w;
  logic            v10_q, tir10_q;
  logic [RW-1:0]   rs2_q, rp2_q;

  assign s10_w  = d4_q[fdr_pkg::DIV_STAGES-1];
  assign rs_w   = {s10_w.ge_s, qs_w};
  assign rp_w   = {s10_w.ge_p, qp_w};
  assign rs2p_w = rs_w * rs_w;
  assign rp2p_w = rp_w * rp_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
    end else begin
      v10_q <= dvs_v & dvp_v;
    end
  end

  always_ff @(posedge clk_i) begin
    rs2_q   <= rs2p_w[fdr_pkg::INT_BITS +: RW];
    rp2_q   <= rp2p_w[fdr_pkg::INT_BITS +: RW];
    tir10_q <= s10_w.tir;
  end

  // mean, round, saturate
  logic [RW:0]                     sum_w;
  logic [RW-1:0]                   mean_w;
  logic [RW-1:0]                   rnd_w;
  logic [RW-fdr_pkg::RES_W:0]      res_w;
  logic                            vo_q;
  fdr_pkg::res_t                   res_q;

  assign sum_w  = {1'b0, rs2_q} + {1'b0, rp2_q};
  assign mean_w = sum_w[RW:1];
  assign rnd_w  = mean_w + (RW'(1) << (fdr_pkg::INT_BITS - fdr_pkg::RES_W));
  assign res_w  = rnd_w[RW-1:fdr_pkg::INT_BITS-fdr_pkg::RES_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tir10_q) begin
      res_q.reflectance    <= fdr_pkg::RESULT_ONE;
      res_q.total_internal <= 1'b1;
    end else begin
      res_q.reflectance    <= (res_w > (RW-fdr_pkg::RES_W+1)'(fdr_pkg::RESULT_ONE))
                              ? fdr_pkg::RESULT_ONE : res_w[fdr_pkg::RES_W-1:0];
      res_q.total_internal <= 1'b0;
    end
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;

  `FDR_ASSERT(a_latency, clk_i, rst_ni, start |-> ##(fdr_pkg::LATENCY) valid_o)
  `FDR_ASSERT(a_origin, clk_i, rst_ni, valid_o |-> $past(start, fdr_pkg::LATENCY))
  `FDR_ASSERT_NEVER(a_sat, clk_i, rst_ni, valid_o && res_o.reflectance > fdr_pkg::RESULT_ONE)
  `FDR_ASSERT(a_tir, clk_i, rst_ni,
      valid_o && res_o.total_internal |-> res_o.reflectance == fdr_pkg::RESULT_ONE)

endmodule

[rtl/fdr_sqrt.sv]
// pipelined integer square root, one root bit per stage
module fdr_sqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [fdr_pkg::RAD_W-1:0]        rad_i,
  output logic                             valid_o,
  output logic [fdr_pkg::ROOT_W-1:0]       root_o
);

  logic                        vld_q  [fdr_pkg::SQRT_STAGES];
  logic [fdr_pkg::RAD_W-1:0]   x_q    [fdr_pkg::SQRT_STAGES];
  logic [fdr_pkg::REM_W-1:0]   rem_q  [fdr_pkg::SQRT_STAGES];
  logic [fdr_pkg::ROOT_W-1:0]  root_q [fdr_pkg::SQRT_STAGES];

  for (genvar k = 0; k < fdr_pkg::SQRT_STAGES; k++) begin : g_stage
    logic                        vin;
    logic [fdr_pkg::RAD_W-1:0]   x_in;
    logic [fdr_pkg::REM_W-1:0]   rem_in;
    logic [fdr_pkg::ROOT_W-1:0]  root_in;
    logic [fdr_pkg::REM_W+1:0]   trial;
    logic [fdr_pkg::REM_W+1:0]   tval;
    logic                        ge;

    if (k == 0) begin : g_first
      assign vin     = valid_i;
      assign x_in    = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign vin     = vld_q[k-1];
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign trial = {rem_in, x_in[fdr_pkg::RAD_W-1 -: 2]};
    assign tval  = (fdr_pkg::REM_W+2)'({root_in, 2'b01});
    assign ge    = trial >= tval;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[k]    <= x_in << 2;
      rem_q[k]  <= ge ? fdr_pkg::REM_W'(trial - tval) : fdr_pkg::REM_W'(trial);
      root_q[k] <= {root_in[fdr_pkg::ROOT_W-2:0], ge};
    end
  end

  assign valid_o = vld_q[fdr_pkg::SQRT_STAGES-1];
  assign root_o  = root_q[fdr_pkg::SQRT_STAGES-1];

endmodule

[rtl/fdr_div.sv]
// pipelined restoring divider, one quotient bit per stage
module fdr_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [fdr_pkg::DEN_W-1:0]         rem_i,
  input  logic [fdr_pkg::DEN_W-1:0]         den_i,
  input  logic [fdr_pkg::DIV_STAGES-1:0]    low_i,
  output logic                              valid_o,
  output logic [fdr_pkg::DIV_STAGES-1:0]    quo_o
);

  logic                              vld_q [fdr_pkg::DIV_STAGES];
  logic [fdr_pkg::DEN_W-1:0]         rem_q [fdr_pkg::DIV_STAGES];
  logic [fdr_pkg::DEN_W-1:0]         den_q [fdr_pkg::DIV_STAGES];
  logic [fdr_pkg::DIV_STAGES-1:0]    low_q [fdr_pkg::DIV_STAGES];
  logic [fdr_pkg::DIV_STAGES-1:0]    quo_q [fdr_pkg::DIV_STAGES];

  for (genvar k = 0; k < fdr_pkg::DIV_STAGES; k++) begin : g_stage
    logic                              vin;
    logic [fdr_pkg::DEN_W-1:0]         rem_in;
    logic [fdr_pkg::DEN_W-1:0]         den_in;
    logic [fdr_pkg::DIV_STAGES-1:0]    low_in;
    logic [fdr_pkg::DIV_STAGES-1:0]    quo_in;
    logic [fdr_pkg::DEN_W:0]           trial;
    logic [fdr_pkg::DEN_W:0]           dext;
    logic                              ge;

    if (k == 0) begin : g_first
      assign vin    = valid_i;
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign low_in = low_i;
      assign quo_in = '0;
    end else begin : g_next
      assign vin    = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {rem_in, low_in[fdr_pkg::DIV_STAGES-1]};
    assign dext  = {1'b0, den_in};
    assign ge    = trial >= dext;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? fdr_pkg::DEN_W'(trial - dext) : fdr_pkg::DEN_W'(trial);
      den_q[k] <= den_in;
      low_q[k] <= low_in << 1;
      quo_q[k] <= {quo_in[fdr_pkg::DIV_STAGES-2:0], ge};
    end
  end

  assign valid_o = vld_q[fdr_pkg::DIV_STAGES-1];
  assign quo_o   = quo_q[fdr_pkg::DIV_STAGES-1];

endmodule
